// ===== rtl/ebc_pkg.sv =====
// Shared types, constants and helpers for the ElGamal byte cipher.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package ebc_pkg;

  // Field element over the prime 9871
  localparam int unsigned EW = 14;
  typedef logic [EW-1:0] elem_t;

  localparam elem_t P_MOD     = 14'd9871;
  localparam elem_t P_MINUS_2 = 14'd9869;
  localparam elem_t GEN_G     = 14'd7527;
  localparam elem_t EPH_RESET = 14'd1795;
  localparam elem_t ELEM_ONE  = 14'd1;
  localparam elem_t ELEM_ZERO = 14'd0;

  // Bit counter for multiplier steps and exponent rounds
  localparam logic [3:0] LAST_BIT = 4'd13;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_KEY  = 2'd1;
  localparam logic [1:0] CFG_EPH  = 2'd2;

  // Mode encoding
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_R,
    ST_WAIT_R,
    ST_POW_B,
    ST_WAIT_B,
    ST_POW_END,
    ST_MUL,
    ST_WAIT_M,
    ST_OUT
  } state_e;

  // Which exponentiation is running
  typedef enum logic [1:0] {
    JOB_C1,
    JOB_MASK_ENC,
    JOB_KB,
    JOB_INV
  } job_e;

  // Multiplier request and response
  typedef struct packed {
    logic  start;
    elem_t a;
    elem_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    elem_t prod;
  } mul_rsp_t;

  // One conditional subtraction: valid for any 14-bit value (< 2p)
  function automatic elem_t reduce_once(input elem_t x);
    elem_t r;
    r = (x >= P_MOD) ? (x - P_MOD) : x;
    return r;
  endfunction

endpackage

// ===== rtl/ebc_mulmod.sv =====
// Bit-serial modular multiplier, a*b mod 9871, one bit of b per cycle.
// Depends on ebc_pkg. Operands must already be below the prime.
`timescale 1ns / 1ps

module ebc_mulmod
  import ebc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  elem_t      a_q, b_q, r_q;
  elem_t      r_d;
  logic [3:0] cnt_q;
  logic       busy_q, done_q;

  logic [EW:0] dbl, dbl_red, sum;
  elem_t       addend;

  // r <- 2r + bit*a, each stage reduced below p
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, P_MOD}) ? (dbl - {1'b0, P_MOD}) : dbl;
    addend  = b_q[EW-1] ? a_q : ELEM_ZERO;
    sum     = dbl_red + {1'b0, addend};
    r_d     = (sum >= {1'b0, P_MOD}) ? elem_t'(sum - {1'b0, P_MOD}) : sum[EW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= LAST_BIT;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  // Datapath, MSB of b first
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      r_q <= ELEM_ZERO;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[EW-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule

// ===== rtl/elgamal_byte_cipher.sv =====
// An item without the first flag runs one 14-step bit-serial multiply. An item with the
// first flag first runs square-and-multiply exponentiations of 14 rounds, two when
// encrypting and one or two when decrypting, each round up to two multiplies. One item
// is in work at a time; the next is taken while a result still waits in the output
// register.
// Reset (rst_ni, async low): mode 0, key 0, exponent 1795, mask 1, c1 hold 0, no error.
`timescale 1ns / 1ps

module elgamal_byte_cipher
  import ebc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [13:0] c1_in, [27:14] value_in, [31:28] zero
  input  logic        s_axis_tuser,   // [0] first
  input  logic        s_axis_tlast,   // last_in
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] c1_out, [27:14] value_out, [31:28] zero
  output logic        m_axis_tuser,   // [0] no_inverse
  output logic        m_axis_tlast    // last_out
);

  // Configuration
  logic  mode_q;
  elem_t key_q, eph_q;

  // Message state
  elem_t mask_q, c1_hold_q;
  logic  inv_q;

  // Sequencer
  state_e state_q, state_d;
  job_e   job_q, job_d;

  // Exponentiation registers
  elem_t      pr_q, pb_q, pe_q;
  logic [3:0] rnd_q;

  // Item latches
  elem_t val_q;
  logic  last_q;

  // Output register
  logic  out_valid_q, out_noinv_q, out_last_q;
  elem_t out_c1_q, out_val_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic  in_acc, out_load, pow_load;
  elem_t pow_base, pow_exp, mul_op;
  elem_t res_c1, res_val;
  logic  res_noinv;

  elem_t c1_in, value_in;
  assign c1_in    = s_axis_tdata[13:0];
  assign value_in = s_axis_tdata[27:14];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  ebc_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = s_axis_tuser ? ST_POW_R : ST_MUL;
      ST_POW_R:   state_d = pe_q[0] ? ST_WAIT_R : ST_POW_B;
      ST_WAIT_R:  if (mul_rsp.done) state_d = ST_POW_B;
      ST_POW_B:   state_d = ST_WAIT_B;
      ST_WAIT_B: begin
        if (mul_rsp.done) state_d = (rnd_q == LAST_BIT) ? ST_POW_END : ST_POW_R;
      end
      ST_POW_END: begin
        unique case (job_q)
          JOB_C1:       state_d = ST_POW_R;
          JOB_KB:       state_d = (pr_q == ELEM_ZERO) ? ST_MUL : ST_POW_R;
          JOB_MASK_ENC: state_d = ST_MUL;
          JOB_INV:      state_d = ST_MUL;
          default:      state_d = ST_MUL;
        endcase
      end
      ST_MUL:     state_d = ST_WAIT_M;
      ST_WAIT_M:  if (mul_rsp.done) state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

    // element multiply operand: byte when encrypting, reduced c2 when decrypting
    mul_op = (mode_q == MODE_ENC) ? {6'b0, val_q[7:0]} : reduce_once(val_q);

    mul_req = '0;
    unique case (state_q)
      ST_POW_R: begin
        mul_req.start = pe_q[0];
        mul_req.a     = pr_q;
        mul_req.b     = pb_q;
      end
      ST_POW_B: begin
        mul_req.start = 1'b1;
        mul_req.a     = pb_q;
        mul_req.b     = pb_q;
      end
      ST_MUL: begin
        mul_req.start = 1'b1;
        mul_req.a     = mul_op;
        mul_req.b     = mask_q;
      end
      default: mul_req = '0;
    endcase

    // exponentiation set-up
    pow_load = 1'b0;
    pow_base = ELEM_ZERO;
    pow_exp  = ELEM_ZERO;
    job_d    = job_q;
    if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tuser) begin
      pow_load = 1'b1;
      if (mode_q == MODE_ENC) begin
        pow_base = GEN_G;
        pow_exp  = eph_q;
        job_d    = JOB_C1;
      end else begin
        pow_base = reduce_once(c1_in);
        pow_exp  = key_q;
        job_d    = JOB_KB;
      end
    end else if (state_q == ST_POW_END && job_q == JOB_C1) begin
      pow_load = 1'b1;
      pow_base = reduce_once(key_q);
      pow_exp  = eph_q;
      job_d    = JOB_MASK_ENC;
    end else if (state_q == ST_POW_END && job_q == JOB_KB && pr_q != ELEM_ZERO) begin
      pow_load = 1'b1;
      pow_base = pr_q;
      pow_exp  = P_MINUS_2;
      job_d    = JOB_INV;
    end

    // result formatting
    if (mode_q == MODE_ENC) begin
      res_c1    = c1_hold_q;
      res_val   = mul_rsp.prod;
      res_noinv = 1'b0;
    end else begin
      res_c1    = ELEM_ZERO;
      res_val   = inv_q ? ELEM_ZERO : {6'b0, mul_rsp.prod[7:0]};
      res_noinv = inv_q;
    end
  end

  // Control and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_C1;
      mode_q      <= MODE_ENC;
      key_q       <= ELEM_ZERO;
      eph_q       <= EPH_RESET;
      mask_q      <= ELEM_ONE;
      c1_hold_q   <= ELEM_ZERO;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      rnd_q       <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_wdata_i[0];
          CFG_KEY:  key_q  <= cfg_wdata_i;
          CFG_EPH:  eph_q  <= cfg_wdata_i;
          default:  ;
        endcase
      end

      // decrypt keeps the reduced c1 of the message
      if (in_acc && s_axis_tuser && mode_q == MODE_DEC) c1_hold_q <= reduce_once(c1_in);

      // round counter
      if (pow_load) rnd_q <= '0;
      else if (state_q == ST_WAIT_B && mul_rsp.done) rnd_q <= rnd_q + 4'd1;

      // end of an exponentiation
      if (state_q == ST_POW_END) begin
        unique case (job_q)
          JOB_C1:       c1_hold_q <= pr_q;
          JOB_MASK_ENC: begin
            mask_q <= pr_q;
            inv_q  <= 1'b0;
          end
          JOB_KB: begin
            if (pr_q == ELEM_ZERO) begin
              mask_q <= ELEM_ZERO;
              inv_q  <= 1'b1;
            end
          end
          JOB_INV: begin
            mask_q <= pr_q;
            inv_q  <= 1'b0;
          end
          default: ;
        endcase
      end

      // output valid
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      val_q  <= value_in;
      last_q <= s_axis_tlast;
    end

    // square-and-multiply, exponent LSB first
    if (pow_load) begin
      pr_q <= ELEM_ONE;
      pb_q <= pow_base;
      pe_q <= pow_exp;
    end else begin
      if (state_q == ST_WAIT_R && mul_rsp.done) pr_q <= mul_rsp.prod;
      if (state_q == ST_WAIT_B && mul_rsp.done) begin
        pb_q <= mul_rsp.prod;
        pe_q <= {1'b0, pe_q[EW-1:1]};
      end
    end

    if (out_load) begin
      out_c1_q    <= res_c1;
      out_val_q   <= res_val;
      out_noinv_q <= res_noinv;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_val_q, out_c1_q};
  assign m_axis_tuser  = out_noinv_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/ebc_checker.sv =====
// Port-level assertions for the ElGamal byte cipher, bound to the top level.
// Depends on ebc_pkg and elgamal_byte_cipher.
`timescale 1ns / 1ps

module ebc_checker
  import ebc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // One item in work at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Error result carries zero fields
  a_noinv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[27:0] == 28'd0)
    else $error("no_inverse result with non-zero fields");

  // Results are field elements
  a_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:0] < P_MOD) && (m_axis_tdata[27:14] < P_MOD))
    else $error("result not reduced below the prime");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind elgamal_byte_cipher ebc_checker u_ebc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/testbench.sv =====
// Self-checking testbench for elgamal_byte_cipher: directed and random item streams
// checked against an in-bench model of the cipher. Depends on rtl/ebc_pkg.sv and the block.
`timescale 1ns / 1ps

module testbench;
  import ebc_pkg::*;

  localparam int unsigned PRIME         = 32'(P_MOD);
  localparam int          STALL_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 50;

  typedef struct packed {
    elem_t c1;
    elem_t value;
    logic  no_inv;
    logic  last;
  } cipher_out_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_MODE;
  logic [13:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [13:0] c1_in, [27:14] value_in, [31:28] zero
  logic        s_axis_tuser  = 1'b0;  // [0] first
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [13:0] c1_out, [27:14] value_out, [31:28] zero
  logic        m_axis_tuser;  // [0] no_inverse
  logic        m_axis_tlast;

  // Model copy of the registers and the held message state
  logic  cfg_mode  = MODE_ENC;
  elem_t cfg_key   = ELEM_ZERO;
  elem_t cfg_eph   = EPH_RESET;
  elem_t held_mask = ELEM_ONE;
  elem_t held_c1   = ELEM_ZERO;
  logic  mask_void = 1'b0;

  cipher_out_t pending_out[$];
  int          fail_count    = 0;
  int          results_seen  = 0;
  int          idle_cycles   = 0;
  logic        steady        = 1'b0;  // no idling on either side

  elgamal_byte_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Field arithmetic mod p
  function automatic int unsigned field_mul(int unsigned a, int unsigned b);
    return ((a % PRIME) * (b % PRIME)) % PRIME;
  endfunction

  function automatic int unsigned field_pow(int unsigned base, int unsigned ex);
    int unsigned acc;
    int unsigned sq;
    acc = 1;
    sq  = base % PRIME;
    while (ex != 0) begin
      if (ex & 1) acc = field_mul(acc, sq);
      sq = field_mul(sq, sq);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Expected result of one item; updates the held mask, c1 and no-inverse flag on a first item
  function automatic cipher_out_t predict_cipher(logic first, elem_t c1_in, elem_t val_in,
                                                 logic last);
    cipher_out_t r;
    int unsigned c1_pow;
    r = '0;
    if (first) begin
      if (cfg_mode == MODE_ENC) begin
        held_c1   = elem_t'(field_pow(32'(GEN_G), 32'(cfg_eph)));
        held_mask = elem_t'(field_pow(32'(cfg_key), 32'(cfg_eph)));
        mask_void = 1'b0;
      end else begin
        c1_pow    = field_pow(32'(c1_in), 32'(cfg_key));
        held_c1   = elem_t'(32'(c1_in) % PRIME);
        mask_void = (c1_pow == 0);
        held_mask = mask_void ? ELEM_ZERO : elem_t'(field_pow(c1_pow, 32'(P_MINUS_2)));
      end
    end
    if (cfg_mode == MODE_ENC) begin
      r.c1    = held_c1;
      r.value = elem_t'(field_mul(32'(val_in[7:0]), 32'(held_mask)));
    end else if (mask_void) begin
      r.no_inv = 1'b1;
    end else begin
      r.value = elem_t'(field_mul(32'(val_in), 32'(held_mask)) & 32'hFF);
    end
    r.last = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < 50)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what, got,
               want);
    fail_count++;
  endtask

  // Send one item; now and then the input idles until the block is ready, and a little past
  task automatic send_item(input logic first, input elem_t c1_in, input elem_t val_in,
                           input logic last);
    if (!steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (!s_axis_tready);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, val_in, c1_in};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_out.push_back(predict_cipher(first, c1_in, val_in, last));
  endtask

  // Drain all results, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MODE: cfg_mode = data[0];
      CFG_KEY:  cfg_key  = data;
      CFG_EPH:  cfg_eph  = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input elem_t key, input elem_t eph);
    wait_idle();
    write_reg(CFG_MODE, {13'd0, mode});
    write_reg(CFG_KEY, key);
    write_reg(CFG_EPH, eph);
  endtask

  // Items before any first use mask 1 and c1 hold 0, in both modes
  task automatic test_no_first_seen();
    send_item(1'b0, 14'h3FFF, 14'h3FFF, 1'b0);
    send_item(1'b0, 14'd0, 14'd0, 1'b1);
    wait_idle();
    write_reg(CFG_MODE, {13'd0, MODE_DEC});
    send_item(1'b0, 14'd0, 14'h3FFF, 1'b0);
    send_item(1'b0, 14'h3FFF, P_MOD, 1'b1);
  endtask

  // Encrypt: reset exponent, zero and top exponents, out-of-range key, high plaintext bits
  task automatic test_encrypt_edges();
    wait_idle();
    write_reg(CFG_MODE, {13'd0, MODE_ENC});
    send_item(1'b1, 14'h3FFF, 14'd255, 1'b0);
    send_item(1'b0, 14'd0, 14'd1, 1'b1);
    set_config(MODE_ENC, 14'd9870, 14'd0);
    send_item(1'b1, 14'd0, 14'd200, 1'b1);
    set_config(MODE_ENC, 14'h3FFF, 14'h3FFF);
    send_item(1'b1, 14'd0, 14'h3F80, 1'b0);
    send_item(1'b0, 14'd0, 14'd127, 1'b1);
    set_config(MODE_ENC, 14'd9870, 14'd9870);
    send_item(1'b1, 14'd0, 14'd255, 1'b1);
  endtask

  // Decrypt: zero key, c1 of zero or p (no inverse), out-of-range c1 and c2
  task automatic test_decrypt_edges();
    set_config(MODE_DEC, 14'd0, 14'd1);
    send_item(1'b1, 14'd0, 14'd9870, 1'b0);
    send_item(1'b0, 14'd0, 14'h3FFF, 1'b1);
    set_config(MODE_DEC, 14'd9870, 14'd1);
    send_item(1'b1, 14'd0, 14'd500, 1'b1);
    send_item(1'b1, P_MOD, 14'd500, 1'b0);
    send_item(1'b0, 14'd0, 14'd1, 1'b1);
    set_config(MODE_DEC, 14'h3FFF, 14'd1);
    send_item(1'b1, 14'h3FFF, P_MOD, 1'b1);
    send_item(1'b1, 14'd1, 14'h3FFF, 1'b1);
  endtask

  // Mode flipped inside a message: the held mask and c1 carry over
  task automatic test_mode_switch();
    set_config(MODE_DEC, 14'd9870, 14'd1);
    send_item(1'b1, P_MOD, 14'd3, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, {13'd0, MODE_ENC});
    send_item(1'b0, 14'd0, 14'd255, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, {13'd0, MODE_DEC});
    send_item(1'b0, 14'd0, 14'd42, 1'b1);
    send_item(1'b1, 14'd5000, 14'd7, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, {13'd0, MODE_ENC});
    send_item(1'b0, 14'h2AAA, 14'd9, 1'b1);
  endtask

  function automatic elem_t pick_exponent();
    case ($urandom_range(5))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return 14'd9870;
      3:       return 14'h3FFF;
      default: return elem_t'($urandom_range(16383));
    endcase
  endfunction

  // Random messages over several settings; mostly well-formed, some with random flags
  task automatic test_random_traffic();
    int    left;
    int    msg_len;
    logic  noisy;
    logic  first;
    logic  last;
    elem_t c1_in;
    elem_t val_in;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_config(logic'(phase % 2), pick_exponent(), pick_exponent());
      steady = (phase == 3);
      left   = PHASE_ITEMS;
      while (left > 0) begin
        msg_len = $urandom_range(1, 8);
        if (msg_len > left) msg_len = left;
        noisy   = ($urandom_range(99) < 15);
        for (int j = 0; j < msg_len; j++) begin
          first = noisy ? logic'($urandom_range(1)) : (j == 0);
          last  = noisy ? logic'($urandom_range(1)) : (j == msg_len - 1);
          case ($urandom_range(19))
            0:       c1_in = 14'd0;
            1:       c1_in = P_MOD;
            2:       c1_in = elem_t'($urandom_range(16383));
            default: c1_in = elem_t'($urandom_range(9870, 1));
          endcase
          if ($urandom_range(99) < 20)
            val_in = elem_t'($urandom_range(16383));
          else if (cfg_mode == MODE_ENC)
            val_in = elem_t'($urandom_range(255));
          else
            val_in = elem_t'($urandom_range(9870));
          send_item(first, c1_in, val_in, last);
          left--;
        end
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, and each result checked against the oldest expectation
  always @(posedge clk_i) begin : result_side
    cipher_out_t want;
    m_axis_tready <= steady || ($urandom_range(99) >= 9);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected item, tdata", m_axis_tdata, 0);
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[13:0] !== want.c1)
          report_mismatch("c1_out", 32'(m_axis_tdata[13:0]), 32'(want.c1));
        if (m_axis_tdata[27:14] !== want.value)
          report_mismatch("value_out", 32'(m_axis_tdata[27:14]), 32'(want.value));
        if (m_axis_tdata[31:28] !== 4'b0000)
          report_mismatch("tdata padding", 32'(m_axis_tdata[31:28]), 0);
        if (m_axis_tuser !== want.no_inv)
          report_mismatch("no_inverse", 32'(m_axis_tuser), 32'(want.no_inv));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_out", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("** elgamal_byte_cipher: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_first_seen();
    test_encrypt_edges();
    test_decrypt_edges();
    test_mode_switch();
    test_random_traffic();
    wait_idle();
    if (pending_out.size() != 0)
      report_mismatch("results outstanding", 0, pending_out.size());
    if (fail_count == 0) begin
      $display("** elgamal_byte_cipher: PASSED **");
    end else begin
      $display("** elgamal_byte_cipher: FAILED **");
    end
    $finish;
  end

endmodule
